// ===== hdl/assert_macros.svh =====
// assertion macros used by sprite_screen_projection_unit
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("implication check failed");
`define ASSERT_NXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("next cycle check failed");
`else
`define ASSERT_IMP(lbl, clk, rst_n, a, b)
`define ASSERT_NXT(lbl, clk, rst_n, a, b)
`endif
`endif

// ===== hdl/ssp_pkg.sv =====
// shared constants, register codes and result type of the sprite projection unit
// no dependencies
package ssp_pkg;

  localparam int POS_FRAC_BITS_DEF = 12;
  localparam int SCREEN_BITS_DEF   = 12;
  localparam int DIR_FRAC_BITS     = 14;

  localparam int POS_W      = 24;
  localparam int DIR_W      = 16;
  localparam int REL_W      = 25;
  localparam int PROD_W     = 41;
  localparam int NUM_W      = 42;
  localparam int DETP_W     = 32;
  localparam int DET_W      = 33;
  localparam int NXM_W      = 41;
  localparam int DETM_W     = 32;
  localparam int COL_W      = 21;
  localparam int SIZE_W     = 16;
  localparam int SROW_W     = 11;
  localparam int EROW_W     = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 128;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PLAYER_X  = 3'd0,
    CFG_PLAYER_Y  = 3'd1,
    CFG_DIR_X     = 3'd2,
    CFG_DIR_Y     = 3'd3,
    CFG_PLANE_X   = 3'd4,
    CFG_PLANE_Y   = 3'd5,
    CFG_SCREEN_W  = 3'd6,
    CFG_SCREEN_H  = 3'd7
  } cfg_reg_e;

  localparam logic [DIR_W-1:0] DIR_X_RST   = 16'd16384;
  localparam logic [DIR_W-1:0] PLANE_Y_RST = 16'd10813;
  localparam int               SCREEN_W_RST = 640;
  localparam int               SCREEN_H_RST = 480;

  typedef struct packed {
    logic                     in_front;
    logic [EROW_W-1:0]        end_row;
    logic [SROW_W-1:0]        start_row;
    logic signed [COL_W-1:0]  end_column;
    logic signed [COL_W-1:0]  start_column;
    logic [SIZE_W-1:0]        sprite_size;
    logic signed [COL_W-1:0]  center_column;
    logic signed [POS_W-1:0]  depth;
  } res_t;

endpackage

// ===== hdl/sprite_screen_projection_unit.sv =====
// top level of the sprite screen projection unit
// depends on ssp_pkg, ssp_div and assert_macros.svh
`include "assert_macros.svh"

// Projects one sprite world position per transaction into camera depth, centre
// column, square size and clipped screen bounds, using the player position, view
// direction, camera plane and screen size held in the configuration registers.
// One sprite is accepted every cycle while the output buffer has room. The pipeline
// is four stages of subtract, multiply and magnitude, a 55 stage divider for the
// camera transform, three stages of saturate, multiply and magnitude, a second
// divider of DIV2_N stages, DIV2_N = max(SCREEN_BITS + 23, SCREEN_BITS +
// POS_FRAC_BITS), for centre column and size, then the centre, size and depth
// stage, the bounds logic and the output register. A two entry output buffer lets
// a new sprite enter while one result waits to be taken. The user must write
// registers only while no sprite is in flight; the block does not enforce it.
module sprite_screen_projection_unit #(
  parameter int POS_FRAC_BITS = ssp_pkg::POS_FRAC_BITS_DEF,
  parameter int SCREEN_BITS   = ssp_pkg::SCREEN_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ssp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ssp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // sprite_x [23:0], sprite_y [47:24]
  input  logic [ssp_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // depth [23:0], center_column [44:24], sprite_size [60:45], start_column [81:61],
  // end_column [102:82], start_row [113:103], end_row [125:114], zero pad [127:126]
  output logic [ssp_pkg::OUT_DATA_W-1:0]  out_tdata,
  // in_front [0]
  output logic                            out_tuser
);

  import ssp_pkg::*;

  localparam int DIV1_N = NXM_W + DIR_FRAC_BITS;
  localparam int P2_W   = SCREEN_BITS + REL_W;
  localparam int PM_W   = SCREEN_BITS + 23;
  localparam int HN_W   = SCREEN_BITS + POS_FRAC_BITS;
  localparam int DIV2_N = (PM_W > HN_W) ? PM_W : HN_W;
  localparam int TYM_W  = POS_W;
  localparam int BC_W   = 22;
  localparam int BR_W   = 17;

  localparam logic [DIV1_N-1:0] LIM1_NEG = DIV1_N'(1) << (POS_W - 1);
  localparam logic [DIV1_N-1:0] LIM1_POS = LIM1_NEG - DIV1_N'(1);
  localparam logic [DIV2_N-1:0] LIM2_NEG = DIV2_N'(1) << (COL_W - 1);
  localparam logic [DIV2_N-1:0] LIM2_POS = LIM2_NEG - DIV2_N'(1);
  localparam logic [DIV2_N-1:0] SIZE_MAX = DIV2_N'(16'hFFFF);

  // configuration registers
  logic signed [POS_W-1:0]     px_r, py_r;
  logic signed [DIR_W-1:0]     dx_r, dy_r, cx_r, cy_r;
  logic [SCREEN_BITS-1:0]      w_r, h_r;
  logic [SCREEN_BITS-2:0]      hw, hh;

  assign cfg_ready = 1'b1;
  assign hw = w_r[SCREEN_BITS-1:1];
  assign hh = h_r[SCREEN_BITS-1:1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r <= '0;
      py_r <= '0;
      dx_r <= DIR_X_RST;
      dy_r <= '0;
      cx_r <= '0;
      cy_r <= PLANE_Y_RST;
      w_r  <= SCREEN_BITS'(SCREEN_W_RST);
      h_r  <= SCREEN_BITS'(SCREEN_H_RST);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_e'(cfg_index))
        CFG_PLAYER_X: px_r <= cfg_data;
        CFG_PLAYER_Y: py_r <= cfg_data;
        CFG_DIR_X:    dx_r <= cfg_data[DIR_W-1:0];
        CFG_DIR_Y:    dy_r <= cfg_data[DIR_W-1:0];
        CFG_PLANE_X:  cx_r <= cfg_data[DIR_W-1:0];
        CFG_PLANE_Y:  cy_r <= cfg_data[DIR_W-1:0];
        CFG_SCREEN_W: w_r  <= cfg_data[SCREEN_BITS-1:0];
        CFG_SCREEN_H: h_r  <= cfg_data[SCREEN_BITS-1:0];
        default:      ;
      endcase
    end
  end

  // pipeline advances while the output buffer has room
  logic en;
  logic skid_valid_r;
  logic out_valid_r;
  res_t out_r, skid_r;

  assign en        = ~skid_valid_r;
  assign in_tready = en;

  // stage a: position relative to the player
  logic                    va_r;
  logic signed [REL_W-1:0] rx_r, ry_r;
  logic signed [REL_W-1:0] rx_nxt, ry_nxt;

  assign rx_nxt = {in_tdata[23], in_tdata[23:0]} - {px_r[POS_W-1], px_r};
  assign ry_nxt = {in_tdata[47], in_tdata[47:24]} - {py_r[POS_W-1], py_r};

  // stage b: products
  logic                     vb_r;
  logic signed [PROD_W-1:0] p_dyrx_r, p_dxry_r, p_cxry_r, p_cyrx_r;
  logic signed [DETP_W-1:0] p_cxdy_r, p_dxcy_r;

  // stage c: numerators and determinant
  logic                     vc_r;
  logic signed [NUM_W-1:0]  nx_r, ny_r;
  logic signed [DET_W-1:0]  det_r;

  // stage d: magnitudes and signs
  logic                     vd_r;
  logic [NXM_W-1:0]         nxm_r, nym_r;
  logic [DETM_W-1:0]        detm_r;
  logic                     sx_r, sy_r, detz_r;
  logic [NUM_W-1:0]         nx_abs, ny_abs;
  logic [DET_W-1:0]         det_abs;

  assign nx_abs  = nx_r[NUM_W-1] ? NUM_W'(-nx_r) : NUM_W'(nx_r);
  assign ny_abs  = ny_r[NUM_W-1] ? NUM_W'(-ny_r) : NUM_W'(ny_r);
  assign det_abs = det_r[DET_W-1] ? DET_W'(-det_r) : DET_W'(det_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else if (en) begin
      va_r <= in_tvalid;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx_r     <= rx_nxt;
      ry_r     <= ry_nxt;
      p_dyrx_r <= PROD_W'(dy_r) * PROD_W'(rx_r);
      p_dxry_r <= PROD_W'(dx_r) * PROD_W'(ry_r);
      p_cxry_r <= PROD_W'(cx_r) * PROD_W'(ry_r);
      p_cyrx_r <= PROD_W'(cy_r) * PROD_W'(rx_r);
      p_cxdy_r <= DETP_W'(cx_r) * DETP_W'(dy_r);
      p_dxcy_r <= DETP_W'(dx_r) * DETP_W'(cy_r);
      nx_r     <= NUM_W'(p_dyrx_r) - NUM_W'(p_dxry_r);
      ny_r     <= NUM_W'(p_cxry_r) - NUM_W'(p_cyrx_r);
      det_r    <= DET_W'(p_cxdy_r) - DET_W'(p_dxcy_r);
      nxm_r    <= nx_abs[NXM_W-1:0];
      nym_r    <= ny_abs[NXM_W-1:0];
      detm_r   <= det_abs[DETM_W-1:0];
      sx_r     <= nx_r[NUM_W-1] ^ det_r[DET_W-1];
      sy_r     <= ny_r[NUM_W-1] ^ det_r[DET_W-1];
      detz_r   <= (det_r == '0);
    end
  end

  // camera transform dividers
  logic              dvx_valid, dvy_valid;
  logic [DIV1_N-1:0] qx, qy;
  logic              qx_side;
  logic [1:0]        qy_side;

  ssp_div #(.N(DIV1_N), .D(DETM_W), .SW(1)) u_div_tx (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(vd_r),
    .in_num({nxm_r, {DIR_FRAC_BITS{1'b0}}}), .in_den(detm_r), .in_side(sx_r),
    .out_valid(dvx_valid), .out_quo(qx), .out_side(qx_side)
  );

  ssp_div #(.N(DIV1_N), .D(DETM_W), .SW(2)) u_div_ty (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(vd_r),
    .in_num({nym_r, {DIR_FRAC_BITS{1'b0}}}), .in_den(detm_r), .in_side({detz_r, sy_r}),
    .out_valid(dvy_valid), .out_quo(qy), .out_side(qy_side)
  );

  // stage e: sign and saturate tx, ty
  logic                    ve_r;
  logic signed [POS_W-1:0] tx_r, ty_r;
  logic signed [POS_W-1:0] tx_nxt, ty_nxt;

  always_comb begin
    if (qx_side) begin
      tx_nxt = (qx > LIM1_NEG) ? 24'sh800000 : $signed(~qx[POS_W-1:0] + 24'd1);
    end else begin
      tx_nxt = (qx > LIM1_POS) ? 24'sh7FFFFF : $signed(qx[POS_W-1:0]);
    end
    if (qy_side[0]) begin
      ty_nxt = (qy > LIM1_NEG) ? 24'sh800000 : $signed(~qy[POS_W-1:0] + 24'd1);
    end else begin
      ty_nxt = (qy > LIM1_POS) ? 24'sh7FFFFF : $signed(qy[POS_W-1:0]);
    end
    // singular view matrix gives zero depth and offset
    if (qy_side[1]) begin
      tx_nxt = '0;
      ty_nxt = '0;
    end
  end

  // stage f: centre numerator (W/2) * (ty + tx)
  logic                    vf_r;
  logic signed [P2_W-1:0]  prod_f_r;
  logic signed [POS_W-1:0] ty_f_r;
  logic signed [REL_W-1:0] sum_f;

  assign sum_f = {tx_r[POS_W-1], tx_r} + {ty_r[POS_W-1], ty_r};

  // stage g: magnitudes for the second dividers
  logic                    vg_r;
  logic [PM_W-1:0]         pm_g_r;
  logic [TYM_W-1:0]        tym_g_r;
  logic                    sc_g_r, tyz_g_r;
  logic signed [POS_W-1:0] ty_g_r;
  logic [P2_W-1:0]         prod_abs;

  assign prod_abs = prod_f_r[P2_W-1] ? P2_W'(-prod_f_r) : P2_W'(prod_f_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
      vf_r <= 1'b0;
      vg_r <= 1'b0;
    end else if (en) begin
      ve_r <= dvy_valid;
      vf_r <= ve_r;
      vg_r <= vf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tx_r     <= tx_nxt;
      ty_r     <= ty_nxt;
      prod_f_r <= P2_W'($signed({1'b0, hw})) * P2_W'(sum_f);
      ty_f_r   <= ty_r;
      pm_g_r   <= prod_abs[PM_W-1:0];
      tym_g_r  <= ty_f_r[POS_W-1] ? (~ty_f_r + 24'd1) : ty_f_r;
      sc_g_r   <= prod_f_r[P2_W-1] ^ ty_f_r[POS_W-1];
      tyz_g_r  <= (ty_f_r == '0);
      ty_g_r   <= ty_f_r;
    end
  end

  // centre column and size dividers
  logic              dvc_valid, dvs_valid;
  logic [DIV2_N-1:0] qc, qs;
  logic [POS_W:0]    qc_side;
  logic              qs_side;

  ssp_div #(.N(DIV2_N), .D(TYM_W), .SW(POS_W + 1)) u_div_center (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(vg_r),
    .in_num(DIV2_N'(pm_g_r)), .in_den(tym_g_r), .in_side({ty_g_r, sc_g_r}),
    .out_valid(dvc_valid), .out_quo(qc), .out_side(qc_side)
  );

  ssp_div #(.N(DIV2_N), .D(TYM_W), .SW(1)) u_div_size (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(vg_r),
    .in_num(DIV2_N'({h_r, {POS_FRAC_BITS{1'b0}}})), .in_den(tym_g_r), .in_side(tyz_g_r),
    .out_valid(dvs_valid), .out_quo(qs), .out_side(qs_side)
  );

  // stage h: centre, size, depth
  logic                    vh_r;
  logic signed [COL_W-1:0] cen_h_r, cen_nxt;
  logic [SIZE_W-1:0]       size_h_r, size_nxt;
  logic signed [POS_W-1:0] depth_h_r, depth_nxt;
  logic                    front_h_r;

  assign depth_nxt = qc_side[POS_W:1];

  always_comb begin
    if (qc_side[0]) begin
      cen_nxt = (qc > LIM2_NEG) ? 21'sh100000 : $signed(~qc[COL_W-1:0] + 21'd1);
    end else begin
      cen_nxt = (qc > LIM2_POS) ? 21'sh0FFFFF : $signed(qc[COL_W-1:0]);
    end
    size_nxt = (qs > SIZE_MAX) ? 16'hFFFF : qs[SIZE_W-1:0];
    // zero depth: centre at mid screen, size saturated
    if (qs_side) begin
      cen_nxt  = $signed(COL_W'({1'b0, hw}));
      size_nxt = 16'hFFFF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vh_r <= 1'b0;
    end else if (en) begin
      vh_r <= dvc_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cen_h_r   <= cen_nxt;
      size_h_r  <= size_nxt;
      depth_h_r <= depth_nxt;
      front_h_r <= ~depth_nxt[POS_W-1] && (depth_nxt != '0);
    end
  end

  // bounds around the centre, clamped to the screen
  logic [SIZE_W-2:0]      half;
  logic signed [BC_W-1:0] cen_s, half_c, w_s, scol_w, ecol_w, wm1_c;
  logic signed [BR_W-1:0] hh_s, half_r, h_s, srow_w, erow_w, hm1_r;
  res_t                   push_res;
  logic                   push;

  assign half   = size_h_r[SIZE_W-1:1];
  assign cen_s  = {cen_h_r[COL_W-1], cen_h_r};
  assign half_c = $signed({{(BC_W-SIZE_W+1){1'b0}}, half});
  assign w_s    = $signed({{(BC_W-SCREEN_BITS){1'b0}}, w_r});
  assign wm1_c  = w_s - 22'sd1;
  assign scol_w = cen_s - half_c;
  assign ecol_w = cen_s + half_c;
  assign hh_s   = $signed({{(BR_W-SCREEN_BITS+1){1'b0}}, hh});
  assign half_r = $signed({{(BR_W-SIZE_W+1){1'b0}}, half});
  assign h_s    = $signed({{(BR_W-SCREEN_BITS){1'b0}}, h_r});
  assign hm1_r  = h_s - 17'sd1;
  assign srow_w = hh_s - half_r;
  assign erow_w = half_r + hh_s;

  always_comb begin
    push_res.depth         = depth_h_r;
    push_res.in_front      = front_h_r;
    push_res.center_column = cen_h_r;
    push_res.sprite_size   = size_h_r;
    push_res.start_column  = (scol_w < 0) ? '0 : scol_w[COL_W-1:0];
    push_res.end_column    = (ecol_w >= w_s) ? wm1_c[COL_W-1:0] : ecol_w[COL_W-1:0];
    push_res.start_row     = (srow_w < 0) ? '0 : srow_w[SROW_W-1:0];
    if (erow_w >= h_s) begin
      push_res.end_row = (hm1_r < 0) ? '0 : hm1_r[EROW_W-1:0];
    end else begin
      push_res.end_row = erow_w[EROW_W-1:0];
    end
  end

  assign push = vh_r && en;

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r  <= skid_valid_r || push;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      out_r <= skid_valid_r ? skid_r : push_res;
    end else if (push) begin
      skid_r <= push_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.in_front;
  assign out_tdata  = {2'b00, out_r.end_row, out_r.start_row, out_r.end_column,
                       out_r.start_column, out_r.sprite_size, out_r.center_column,
                       out_r.depth};

  // checks
  `ASSERT_IMP(a_skid_needs_out, clk, rst_n, skid_valid_r, out_valid_r)
  `ASSERT_IMP(a_no_accept_when_full, clk, rst_n, skid_valid_r, !in_tready)
  `ASSERT_NXT(a_stalled_result_held, clk, rst_n, out_valid_r && !out_tready, out_valid_r)
  `ASSERT_IMP(a_dividers_aligned, clk, rst_n, dvx_valid || dvy_valid,
              dvx_valid && dvy_valid && (dvc_valid == dvs_valid))

endmodule

// ===== hdl/ssp_div.sv =====
// pipelined restoring divider, one quotient bit per stage, side data carried along
// no dependencies
module ssp_div #(
  parameter int N  = 55,
  parameter int D  = 32,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [N-1:0]  in_num,
  input  logic [D-1:0]  in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [N-1:0]  out_quo,
  output logic [SW-1:0] out_side
);

  logic          vld_r  [N];
  logic [D-1:0]  rem_r  [N];
  logic [N-1:0]  dq_r   [N];
  logic [D-1:0]  den_r  [N];
  logic [SW-1:0] side_r [N];

  genvar k;
  generate
    for (k = 0; k < N; k++) begin : g_step
      logic          vld_i;
      logic [D-1:0]  rem_i;
      logic [D-1:0]  den_i;
      logic [N-1:0]  dq_i;
      logic [SW-1:0] side_i;
      logic [D:0]    trial;
      logic [D+1:0]  diff;
      logic          take;

      if (k == 0) begin : g_first
        assign vld_i  = in_valid;
        assign rem_i  = '0;
        assign dq_i   = in_num;
        assign den_i  = in_den;
        assign side_i = in_side;
      end else begin : g_next
        assign vld_i  = vld_r[k-1];
        assign rem_i  = rem_r[k-1];
        assign dq_i   = dq_r[k-1];
        assign den_i  = den_r[k-1];
        assign side_i = side_r[k-1];
      end

      // shift in next dividend bit and try the subtraction
      assign trial = {rem_i, dq_i[N-1]};
      assign diff  = {1'b0, trial} - {2'b00, den_i};
      assign take  = ~diff[D+1];

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[k] <= 1'b0;
        end else if (en) begin
          vld_r[k] <= vld_i;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k]  <= take ? diff[D-1:0] : trial[D-1:0];
          dq_r[k]   <= {dq_i[N-2:0], take};
          den_r[k]  <= den_i;
          side_r[k] <= side_i;
        end
      end
    end
  endgenerate

  assign out_valid = vld_r[N-1];
  assign out_quo   = dq_r[N-1];
  assign out_side  = side_r[N-1];

endmodule
